/* rtl/dtsc_pkg.sv */
// ----------------------------------------------------------------------------
// dtsc_pkg
// Shared constants for the date-time stamp checker: character codes,
// stamp positions, accepted stamp lengths, tee counter values and state widths.
// ----------------------------------------------------------------------------
package dtsc_pkg;

  // state widths
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned TEE_W  = 2;

  // character codes, compared as unsigned bytes
  localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CH_1 = 8'h31;
  localparam logic [CHAR_W-1:0] CH_2 = 8'h32;
  localparam logic [CHAR_W-1:0] CH_3 = 8'h33;
  localparam logic [CHAR_W-1:0] CH_4 = 8'h34;
  localparam logic [CHAR_W-1:0] CH_6 = 8'h36;
  localparam logic [CHAR_W-1:0] CH_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CH_T = 8'h54;
  localparam logic [CHAR_W-1:0] CH_Z = 8'h5A;

  // stamp positions, counted from zero
  localparam logic [POS_W-1:0] POS_DATE_END = 5'd8;   // first non-date position
  localparam logic [POS_W-1:0] POS_MONTH    = 5'd5;   // second month digit
  localparam logic [POS_W-1:0] POS_DAY      = 5'd7;   // second day digit
  localparam logic [POS_W-1:0] POS_TEE      = 5'd8;
  localparam logic [POS_W-1:0] POS_HOUR     = 5'd10;  // second hour character
  localparam logic [POS_W-1:0] POS_MINUTE   = 5'd11;  // first minute character
  localparam logic [POS_W-1:0] POS_SECOND   = 5'd13;  // first second character
  localparam logic [POS_W-1:0] POS_ZULU     = 5'd15;
  localparam logic [POS_W-1:0] POS_LONG     = 5'd16;  // from here on too long
  localparam logic [POS_W-1:0] POS_MAX      = 5'd17;  // saturation point

  // accepted stamp lengths
  localparam logic [POS_W-1:0] LEN_BASIC = 5'd15;
  localparam logic [POS_W-1:0] LEN_UTC   = 5'd16;

  // tee counter values
  localparam logic [TEE_W-1:0] TEE_ONE = 2'd1;
  localparam logic [TEE_W-1:0] TEE_MAX = 2'd2;

endpackage

/* rtl/date_time_stamp_checker.sv */
// ----------------------------------------------------------------------------
// date_time_stamp_checker
// Streams a YYYYMMDDThhmmss[Z] stamp one character per transfer and gives
// one verdict transfer per stamp, on the character marked by tlast.
// ----------------------------------------------------------------------------
// One character per cycle is taken in steady state. A character is held in
// an input register and checked in the next cycle against the running state
// (position, T count, reject flag, previous character); the last character of
// a stamp writes the verdict into the output register as it leaves the input
// register. The input keeps flowing while a verdict waits, and stalls only
// when a last character finds the output register still full. The state
// clears after each verdict.
module date_time_stamp_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_byte
  input  logic       in_tlast,   // last_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] stamp_valid, [1] stamp_utc, [7:2] zero
);

  // input register
  logic                        in_valid_r;
  logic [dtsc_pkg::CHAR_W-1:0] in_char_r;
  logic                        in_last_r;

  // running stamp state
  logic [dtsc_pkg::POS_W-1:0]  pos_r,  pos_nxt;
  logic [dtsc_pkg::TEE_W-1:0]  tee_r,  tee_nxt;
  logic                        rej_r,  rej_nxt;
  logic [dtsc_pkg::CHAR_W-1:0] prev_r;

  // result register
  logic out_valid_r;
  logic out_ok_r,  out_ok_nxt;
  logic out_utc_r, out_utc_nxt;

  logic fail;
  logic advance;
  logic verdict;

  // the held character moves on unless it is a last one facing a full output
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign verdict   = advance && in_last_r;
  assign in_tready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // positional check
  dtsc_rule u_rule (
    .pos       (pos_r),
    .cur_char  (in_char_r),
    .prev_char (prev_r),
    .fail      (fail)
  );

  // next state and verdict
  always_comb begin
    rej_nxt = rej_r || fail;
    tee_nxt = tee_r;
    if ((in_char_r == dtsc_pkg::CH_T) && (tee_r < dtsc_pkg::TEE_MAX)) begin
      tee_nxt = tee_r + dtsc_pkg::TEE_ONE;
    end
    pos_nxt = (pos_r < dtsc_pkg::POS_MAX) ? pos_r + 5'd1 : dtsc_pkg::POS_MAX;
    out_ok_nxt  = !rej_nxt && (tee_nxt == dtsc_pkg::TEE_ONE)
               && (pos_nxt >= dtsc_pkg::LEN_BASIC);
    out_utc_nxt = out_ok_nxt && (pos_nxt == dtsc_pkg::LEN_UTC);
  end

  // stamp state, cleared after each verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      tee_r  <= '0;
      rej_r  <= 1'b0;
      prev_r <= '0;
    end else if (verdict) begin
      pos_r  <= '0;
      tee_r  <= '0;
      rej_r  <= 1'b0;
      prev_r <= '0;
    end else if (advance) begin
      pos_r  <= pos_nxt;
      tee_r  <= tee_nxt;
      rej_r  <= rej_nxt;
      prev_r <= in_char_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (verdict) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict) begin
      out_ok_r  <= out_ok_nxt;
      out_utc_r <= out_utc_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_utc_r, out_ok_r};

  // position counter never passes its saturation point
  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= dtsc_pkg::POS_MAX)
    else $error("position counter beyond saturation");

  // tee counter never passes two
  a_tee_sat: assert property (@(posedge clk) disable iff (!rst_n)
    tee_r <= dtsc_pkg::TEE_MAX)
    else $error("tee counter beyond saturation");

  // a verdict clears the stamp state
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    verdict |=> (pos_r == '0) && (tee_r == '0) && !rej_r)
    else $error("stamp state not cleared after verdict");

  // a verdict is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !verdict)
    else $error("pending verdict overwritten");

  // utc flag only on a valid stamp
  a_utc_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_utc_r || out_ok_r))
    else $error("utc flag without valid stamp");

endmodule

/* rtl/dtsc_rule.sv */
// ----------------------------------------------------------------------------
// dtsc_rule
// Positional rule check: flags a character that breaks the rule for the
// position it sits at, given the character before it.
// ----------------------------------------------------------------------------
module dtsc_rule (
  input  logic [dtsc_pkg::POS_W-1:0]  pos,
  input  logic [dtsc_pkg::CHAR_W-1:0] cur_char,
  input  logic [dtsc_pkg::CHAR_W-1:0] prev_char,
  output logic                        fail
);

  logic is_digit;
  logic rule_fail;

  // date characters must be decimal digits
  assign is_digit = (cur_char >= dtsc_pkg::CH_0) && (cur_char <= dtsc_pkg::CH_9);

  // per-position rule
  always_comb begin
    case (pos)
      dtsc_pkg::POS_MONTH: begin
        rule_fail = (prev_char >= dtsc_pkg::CH_2)
                 || ((prev_char == dtsc_pkg::CH_1) && (cur_char >= dtsc_pkg::CH_3))
                 || ((prev_char == dtsc_pkg::CH_0) && (cur_char == dtsc_pkg::CH_0));
      end
      dtsc_pkg::POS_DAY: begin
        rule_fail = ((prev_char == dtsc_pkg::CH_0) && (cur_char == dtsc_pkg::CH_0))
                 || ((prev_char == dtsc_pkg::CH_3) && (cur_char >= dtsc_pkg::CH_2))
                 || (prev_char >= dtsc_pkg::CH_4);
      end
      dtsc_pkg::POS_TEE: begin
        rule_fail = (cur_char != dtsc_pkg::CH_T);
      end
      dtsc_pkg::POS_HOUR: begin
        rule_fail = ((prev_char == dtsc_pkg::CH_2) && (cur_char >= dtsc_pkg::CH_4))
                 || (prev_char >= dtsc_pkg::CH_3);
      end
      dtsc_pkg::POS_MINUTE, dtsc_pkg::POS_SECOND: begin
        rule_fail = (cur_char >= dtsc_pkg::CH_6);
      end
      dtsc_pkg::POS_ZULU: begin
        rule_fail = (cur_char != dtsc_pkg::CH_Z);
      end
      default: begin
        rule_fail = (pos >= dtsc_pkg::POS_LONG);
      end
    endcase
  end

  assign fail = rule_fail || ((pos < dtsc_pkg::POS_DATE_END) && !is_digit);

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for date_time_stamp_checker. Stamps go in one character
// per transfer and are tracked by a cycle-free predictor of the checker
// rules. Each verdict transfer is compared with the oldest pending verdict.
// Directed stamps cover the extreme values and the short and overlong stamps.
// The random stamps are mostly well formed, some with bytes altered, with
// wrong lengths, or pure noise. Both sides of the block stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_CHARS = 1650;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned TAIL_CYCLES  = 8;

  typedef logic [dtsc_pkg::CHAR_W-1:0] char_t;
  typedef logic [dtsc_pkg::POS_W-1:0]  pos_t;
  typedef logic [dtsc_pkg::TEE_W-1:0]  tee_t;

  typedef struct packed {
    logic ok;
    logic utc;
  } verdict_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  // predictor state: position, T count, reject flag, previous character
  pos_t  pos_q   = '0;
  tee_t  tees_q  = '0;
  logic  bad_q   = 1'b0;
  char_t prev_q  = '0;

  verdict_t verdict_q[$];
  char_t    stamp_buf[$];

  logic calm = 1'b0;   // no idling on either side while set
  int   errors = 0;
  int   cycles = 0;
  int   chars_sent = 0;
  int   stamps_sent = 0;
  int   valid_seen = 0;
  int   utc_seen = 0;
  int   rejected_seen = 0;

  date_time_stamp_checker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // positional rule for one character, given the character before it
  function automatic logic char_breaks_rule(input pos_t pos, input char_t c, input char_t p);
    if (pos < dtsc_pkg::POS_DATE_END && !(c >= dtsc_pkg::CH_0 && c <= dtsc_pkg::CH_9))
      return 1'b1;
    case (pos)
      dtsc_pkg::POS_MONTH:
        return p >= dtsc_pkg::CH_2 || (p == dtsc_pkg::CH_1 && c >= dtsc_pkg::CH_3)
            || (p == dtsc_pkg::CH_0 && c == dtsc_pkg::CH_0);
      dtsc_pkg::POS_DAY:
        return (p == dtsc_pkg::CH_0 && c == dtsc_pkg::CH_0)
            || (p == dtsc_pkg::CH_3 && c >= dtsc_pkg::CH_2) || p >= dtsc_pkg::CH_4;
      dtsc_pkg::POS_TEE:
        return c != dtsc_pkg::CH_T;
      dtsc_pkg::POS_HOUR:
        return (p == dtsc_pkg::CH_2 && c >= dtsc_pkg::CH_4) || p >= dtsc_pkg::CH_3;
      dtsc_pkg::POS_MINUTE,
      dtsc_pkg::POS_SECOND:
        return c >= dtsc_pkg::CH_6;
      dtsc_pkg::POS_ZULU:
        return c != dtsc_pkg::CH_Z;
      default:
        return pos >= dtsc_pkg::POS_LONG;
    endcase
  endfunction

  // advance the predictor by one accepted character
  task automatic track_char(input char_t c, input logic last);
    verdict_t v;
    if (char_breaks_rule(pos_q, c, prev_q)) bad_q = 1'b1;
    if (c == dtsc_pkg::CH_T && tees_q < dtsc_pkg::TEE_MAX) tees_q = tees_q + 1'b1;
    prev_q = c;
    if (pos_q < dtsc_pkg::POS_MAX) pos_q = pos_q + 1'b1;
    if (last) begin
      v.ok  = !bad_q && tees_q == dtsc_pkg::TEE_ONE && pos_q >= dtsc_pkg::LEN_BASIC;
      v.utc = v.ok && pos_q == dtsc_pkg::LEN_UTC;
      verdict_q.push_back(v);
      pos_q  = '0;
      tees_q = '0;
      bad_q  = 1'b0;
      prev_q = '0;
    end
  endtask

  // one character transfer; entered and left at a falling edge
  task automatic send_char(input char_t c, input logic last);
    while (!calm && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    track_char(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_stamp();
    int n;
    n = stamp_buf.size();
    for (int i = 0; i < n; i++) send_char(stamp_buf[i], i == n - 1);
    stamps_sent++;
  endtask

  task automatic load_text(input string s);
    stamp_buf.delete();
    for (int i = 0; i < s.len(); i++) stamp_buf.push_back(s[i]);
  endtask

  // hold the input side until every pending verdict has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
  endtask

  function automatic char_t any_byte();
    return char_t'($urandom_range(255, 1));
  endfunction

  function automatic char_t digit_upto(input int unsigned hi);
    return dtsc_pkg::CH_0 + char_t'($urandom_range(hi));
  endfunction

  function automatic char_t pick_byte();
    case ($urandom_range(5))
      0:       return dtsc_pkg::CH_T;
      1:       return dtsc_pkg::CH_Z;
      2:       return 8'hFF;
      3:       return 8'h01;
      4:       return digit_upto(9);
      default: return any_byte();
    endcase
  endfunction

  // date digits mostly in range, time characters near their limits
  task automatic build_well_formed();
    stamp_buf.delete();
    repeat (4) stamp_buf.push_back(digit_upto(9));
    stamp_buf.push_back(($urandom_range(7) == 0) ? dtsc_pkg::CH_2 : digit_upto(1));
    stamp_buf.push_back(digit_upto(9));
    stamp_buf.push_back(digit_upto(4));
    stamp_buf.push_back(digit_upto(9));
    stamp_buf.push_back(dtsc_pkg::CH_T);
    stamp_buf.push_back(digit_upto(3));
    stamp_buf.push_back(digit_upto(9));
    stamp_buf.push_back(digit_upto(6));
    stamp_buf.push_back(digit_upto(9));
    stamp_buf.push_back(digit_upto(6));
    stamp_buf.push_back(digit_upto(9));
    if ($urandom_range(1)) stamp_buf.push_back(dtsc_pkg::CH_Z);
  endtask

  task automatic build_random_stamp();
    int r;
    int len;
    r = $urandom_range(99);
    if (r < 90) build_well_formed();
    if (r >= 55 && r < 80) begin
      // one or two altered characters
      repeat ($urandom_range(2, 1))
        stamp_buf[$urandom_range(stamp_buf.size() - 1)] = pick_byte();
    end else if (r >= 80 && r < 90) begin
      // wrong length: cut short or run past the end
      if ($urandom_range(1)) begin
        len = $urandom_range(14, 1);
        while (stamp_buf.size() > len) void'(stamp_buf.pop_back());
      end else begin
        len = $urandom_range(20, 17);
        while (stamp_buf.size() < len) stamp_buf.push_back(pick_byte());
      end
    end else if (r >= 90) begin
      stamp_buf.delete();
      len = $urandom_range(20, 1);
      repeat (len) stamp_buf.push_back(($urandom_range(3) == 0) ? pick_byte() : any_byte());
    end
  endtask

  // largest date and time values with the zulu suffix, smallest month, day and time without it
  task automatic test_extremes();
    load_text("99991231T235959Z");
    send_stamp();
    load_text("00010101T000000");
    send_stamp();
  endtask

  // single-character stamps with all bits low but one, and all bits high
  task automatic test_short();
    stamp_buf = '{8'h01};
    send_stamp();
    stamp_buf = '{8'hFF};
    send_stamp();
  endtask

  // a correct utc stamp followed by one extra character
  task automatic test_overlong();
    load_text("20240229T120000Z");
    stamp_buf.push_back(dtsc_pkg::CH_Z);
    send_stamp();
  endtask

  task automatic test_random_stamps();
    int start;
    int n;
    start = chars_sent;
    n = 0;
    while (chars_sent - start < RANDOM_CHARS) begin
      calm = (n >= 30 && n < 45);
      if (n == 60) drain();
      build_random_stamp();
      send_stamp();
      n++;
    end
    calm = 1'b0;
  endtask

  // result side stalls
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 12);
  end

  // verdict checker
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict transfer with none pending, got %h", $time, out_tdata);
        errors++;
      end else begin
        v = verdict_q.pop_front();
        if (out_tdata[0] !== v.ok) begin
          $display("%0t: stamp_valid expected %b actual %b", $time, v.ok, out_tdata[0]);
          errors++;
        end
        if (out_tdata[1] !== v.utc) begin
          $display("%0t: stamp_utc expected %b actual %b", $time, v.utc, out_tdata[1]);
          errors++;
        end
        if (out_tdata[7:2] !== 6'd0) begin
          $display("%0t: pad bits expected 0 actual %b", $time, out_tdata[7:2]);
          errors++;
        end
        if (v.ok) valid_seen++;
        else rejected_seen++;
        if (v.utc) utc_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d verdicts pending", $time, verdict_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_extremes();
    test_short();
    drain();
    test_overlong();
    test_random_stamps();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d verdicts never came out", $time, verdict_q.size());
      errors++;
    end
    $display("covered %0d stamps in %0d characters", stamps_sent, chars_sent);
    $display("verdicts: %0d valid (%0d utc), %0d rejected, %0d errors",
             valid_seen, utc_seen, rejected_seen, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
